### src/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants for the top-K score selector
// Score width, register layout, controller states and the cell control word.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int SCORE_W    = 32;
  localparam int TOPK_W     = 5;
  localparam int TOPK_RESET = 5;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_DRAIN
  } tks_state_t;

  // control word broadcast to every cell of the chain
  typedef struct packed {
    logic insert;    // rank the broadcast score into the chain
    logic shift_up;  // move every entry one cell toward the head
    logic clear;     // drop all entries
  } tks_ctrl_t;

endpackage

### src/tks_if.sv
// ----------------------------------------------------------------------------
// tks_if: valid/ready channels of the top-K score selector
// score_if carries one class score per word, result_if one ranked result.
// ----------------------------------------------------------------------------
interface tks_score_if
  import tks_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      last;

  modport source (output valid, output score, output last, input ready);
  modport sink   (input valid, input score, input last, output ready);
endinterface

interface tks_result_if
  import tks_pkg::*;
#(
  parameter int RANK_W = 5,
  parameter int IDX_W  = 10
) ();
  logic                      valid;
  logic                      ready;
  logic [RANK_W-1:0]         rank;
  logic [IDX_W-1:0]          class_index;
  logic signed [SCORE_W-1:0] best_score;
  logic                      final_res;

  modport source (output valid, output rank, output class_index, output best_score,
                  output final_res, input ready);
  modport sink   (input valid, input rank, input class_index, input best_score,
                  input final_res, output ready);
endinterface

### src/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell: one slot of the sorted insertion chain
// Holds one kept entry; takes the new score, its upper neighbor's entry on
// insert, or its lower neighbor's entry while the list drains.
// ----------------------------------------------------------------------------
module tks_cell
  import tks_pkg::*;
#(
  parameter int IDX_W = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tks_ctrl_t                 ctrl,
  input  logic signed [SCORE_W-1:0] new_score,
  input  logic [IDX_W-1:0]          new_index,
  input  logic                      prev_better,
  input  logic                      prev_valid,
  input  logic signed [SCORE_W-1:0] prev_score,
  input  logic [IDX_W-1:0]          prev_index,
  input  logic                      next_valid,
  input  logic signed [SCORE_W-1:0] next_score,
  input  logic [IDX_W-1:0]          next_index,
  output logic                      better,
  output logic                      valid,
  output logic signed [SCORE_W-1:0] score,
  output logic [IDX_W-1:0]          index
);

  // strict compare: equal scores stay behind, earlier arrival ranks first
  assign better = !valid || (new_score > score);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert && better) begin
      valid <= prev_better ? prev_valid : 1'b1;
    end else if (ctrl.shift_up) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && better) begin
      if (prev_better) begin
        score <= prev_score;
        index <= prev_index;
      end else begin
        score <= new_score;
        index <= new_index;
      end
    end else if (ctrl.shift_up) begin
      score <= next_score;
      index <= next_index;
    end
  end

endmodule

### src/top_k_score_selector.sv
// ----------------------------------------------------------------------------
// top_k_score_selector: streaming top-K class score selector
// Ranks each incoming score into a sorted chain of MAX_K cells and, on the
// word marked last, drains the best min(top_k, seen) entries in rank order.
// ----------------------------------------------------------------------------
// Throughput: one score word per cycle while a set loads; the cell chain
//   ranks each score in the cycle it is accepted.
// Report: first result valid in the cycle after the last word; then one result
//   per cycle while results is ready; scores are held off until the final result is taken.
// Reset (rst, synchronous): empties the chain, zeroes the class counter,
//   top_k returns to 5. No clearing pass is needed.
module top_k_score_selector
  import tks_pkg::*;
#(
  parameter int MAX_K       = 16,
  parameter int MAX_CLASSES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [TOPK_W-1:0]   cfg_wr_data,
  tks_score_if.sink           scores,
  tks_result_if.source        results
);

  localparam int RANK_W = $clog2(MAX_K + 1);
  localparam int IDX_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  // ---------------------------------------------------------------- config
  logic [TOPK_W-1:0] top_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_k <= TOPK_W'(TOPK_RESET);
    end else if (cfg_wr_en) begin
      top_k <= cfg_wr_data;
    end
  end

  // clamp: zero reports one class, anything above the chain length saturates
  logic [RANK_W-1:0] k_eff;
  always_comb begin
    if (top_k == '0) begin
      k_eff = RANK_W'(1);
    end else if (int'(top_k) > MAX_K) begin
      k_eff = RANK_W'(MAX_K);
    end else begin
      k_eff = RANK_W'(top_k);
    end
  end

  // ---------------------------------------------------------------- control
  tks_state_t        state, state_next;
  tks_ctrl_t         ctrl;
  logic [IDX_W-1:0]  class_cnt, class_cnt_next;
  logic [RANK_W-1:0] kept, kept_next;     // entries held, saturates at MAX_K
  logic [RANK_W-1:0] n_out, n_out_next;   // results to report for this set
  logic [RANK_W-1:0] rank, rank_next;
  logic [RANK_W-1:0] kept_after;
  logic              in_acc, out_acc, is_final;

  assign in_acc     = scores.valid && scores.ready;
  assign out_acc    = results.valid && results.ready;
  assign is_final   = (rank == n_out);
  assign kept_after = (int'(kept) < MAX_K) ? kept + RANK_W'(1) : kept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      class_cnt <= '0;
      kept      <= '0;
      n_out     <= '0;
      rank      <= '0;
    end else begin
      state     <= state_next;
      class_cnt <= class_cnt_next;
      kept      <= kept_next;
      n_out     <= n_out_next;
      rank      <= rank_next;
    end
  end

  always_comb begin
    state_next     = state;
    class_cnt_next = class_cnt;
    kept_next      = kept;
    n_out_next     = n_out;
    rank_next      = rank;
    ctrl           = '0;
    unique case (state)
      ST_LOAD: begin
        if (in_acc) begin
          ctrl.insert = 1'b1;
          kept_next   = kept_after;
          // class index wraps past the configured class count
          class_cnt_next = (class_cnt == IDX_W'(MAX_CLASSES - 1)) ? '0
                                                                  : class_cnt + IDX_W'(1);
          if (scores.last) begin
            n_out_next     = (k_eff < kept_after) ? k_eff : kept_after;
            rank_next      = RANK_W'(1);
            class_cnt_next = '0;
            state_next     = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          if (is_final) begin
            ctrl.clear = 1'b1;
            kept_next  = '0;
            state_next = ST_LOAD;
          end else begin
            ctrl.shift_up = 1'b1;
            rank_next     = rank + RANK_W'(1);
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------- cell chain
  logic                      cell_better [MAX_K];
  logic                      cell_valid  [MAX_K];
  logic signed [SCORE_W-1:0] cell_score  [MAX_K];
  logic [IDX_W-1:0]          cell_index  [MAX_K];

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic                      pb, pv, nv;
    logic signed [SCORE_W-1:0] ps, ns;
    logic [IDX_W-1:0]          pi, ni;

    if (i == 0) begin : g_head
      assign pb = 1'b0;
      assign pv = 1'b0;
      assign ps = '0;
      assign pi = '0;
    end else begin : g_body
      assign pb = cell_better[i-1];
      assign pv = cell_valid[i-1];
      assign ps = cell_score[i-1];
      assign pi = cell_index[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign nv = 1'b0;
      assign ns = '0;
      assign ni = '0;
    end else begin : g_link
      assign nv = cell_valid[i+1];
      assign ns = cell_score[i+1];
      assign ni = cell_index[i+1];
    end

    tks_cell #(.IDX_W(IDX_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_score  (scores.score),
      .new_index  (class_cnt),
      .prev_better(pb),
      .prev_valid (pv),
      .prev_score (ps),
      .prev_index (pi),
      .next_valid (nv),
      .next_score (ns),
      .next_index (ni),
      .better     (cell_better[i]),
      .valid      (cell_valid[i]),
      .score      (cell_score[i]),
      .index      (cell_index[i])
    );
  end

  // ---------------------------------------------------------------- ports
  // head cell is the registered output word; it holds while results stalls
  assign scores.ready        = (state == ST_LOAD);
  assign results.valid       = (state == ST_DRAIN);
  assign results.rank        = rank;
  assign results.class_index = cell_index[0];
  assign results.best_score  = cell_score[0];
  assign results.final_res   = is_final;

endmodule

### src/tks_checker.sv
// ----------------------------------------------------------------------------
// tks_checker: port-level checks for the top-K score selector
// Watches the score and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module tks_checker
  import tks_pkg::*;
#(
  parameter int RANK_W = 5,
  parameter int IDX_W  = 10
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [RANK_W-1:0]         out_rank,
  input logic [IDX_W-1:0]          out_index,
  input logic signed [SCORE_W-1:0] out_score,
  input logic                      out_final
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_rank) && $stable(out_index)
                                && $stable(out_score) && $stable(out_final))
    else $error("result word changed while stalled");

  // last score of a set starts the report in the next cycle at rank 1
  a_report_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> out_valid && out_rank == RANK_W'(1))
    else $error("report did not start after last score");

  // ranks count up by one within a report
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_final |=> out_valid
                                             && out_rank == $past(out_rank) + RANK_W'(1))
    else $error("rank sequence broken");

  // final result ends the report and reopens the score channel
  a_report_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_final |=> in_ready && !out_valid)
    else $error("report did not end after final result");

  // scores are never taken while a report is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("score channel open during report");

endmodule

bind top_k_score_selector tks_checker #(
  .RANK_W(RANK_W),
  .IDX_W (IDX_W)
) u_tks_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (scores.valid),
  .in_ready (scores.ready),
  .in_last  (scores.last),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_rank (results.rank),
  .out_index(results.class_index),
  .out_score(results.best_score),
  .out_final(results.final_res)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming top-K score selector
// Score words stream in through a bursty driver and ranked results drain out
// to a receiver that stalls on its own pattern. A software copy of the sorted
// list predicts every result, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import tks_pkg::*;

  localparam int MAX_K       = 16;
  localparam int MAX_CLASSES = 1024;
  localparam int RANK_W      = 5;
  localparam int IDX_W       = $clog2(MAX_CLASSES);

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  // long receiver hold-off, in cycles; long enough to back up the score input
  localparam int LONG_HOLD = 80;

  // score styles used by the random sets
  typedef enum int {
    SC_FULL,     // any 32-bit pattern
    SC_TIES,     // narrow range, lots of equal scores
    SC_EXTREME,  // max, min, 0, -1, 1
    SC_EDGE      // a few counts off either end of the range
  } score_style_t;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } score_word_t;

  typedef struct {
    logic [RANK_W-1:0]         rank;
    logic [IDX_W-1:0]          class_index;
    logic signed [SCORE_W-1:0] best_score;
    logic                      final_res;
  } ranked_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [TOPK_W-1:0] cfg_wr_data;

  tks_score_if                                      score_ch ();
  tks_result_if #(.RANK_W(RANK_W), .IDX_W(IDX_W))   result_ch ();

  top_k_score_selector #(
    .MAX_K       (MAX_K),
    .MAX_CLASSES (MAX_CLASSES)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .scores      (score_ch),
    .results     (result_ch)
  );

  // --------------------------------------------------------------------------
  // Predicted state: the best entries of the current set, best first.
  // --------------------------------------------------------------------------
  logic signed [SCORE_W-1:0] best_scores [MAX_K];
  logic [IDX_W-1:0]          best_indices [MAX_K];
  int                        best_count = 0;
  logic [IDX_W-1:0]          arrival_index = '0;   // wraps like the block's counter
  logic [TOPK_W-1:0]         sel_top_k = TOPK_W'(TOPK_RESET);

  score_word_t    pending_words [$];   // queued by the stimulus, taken by the driver
  ranked_result_t ranked_due [$];      // results predicted but not yet seen

  int words_queued = 0;
  int words_taken  = 0;
  int failures     = 0;

  // receiver long-hold requests: stimulus bumps the ask, receiver bumps done
  int holds_asked = 0;
  int holds_done  = 0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Rank one accepted score into the list. On the set's last word, emit the
  // best min(K, kept) entries and start the next set empty. Equal scores stay
  // in arrival order, so a newcomer goes behind every entry that is >= it.
  function automatic void rank_score(logic signed [SCORE_W-1:0] s, logic last_word);
    int             pos;
    int             j;
    int             k;
    int             n;
    ranked_result_t r;
    pos = 0;
    while (pos < best_count && best_scores[pos] >= s) pos++;
    // list full and score no higher than every entry: dropped
    if (pos < MAX_K) begin
      j = (best_count < MAX_K) ? best_count : MAX_K - 1;
      while (j > pos) begin
        best_scores[j]  = best_scores[j-1];
        best_indices[j] = best_indices[j-1];
        j--;
      end
      best_scores[pos]  = s;
      best_indices[pos] = arrival_index;
      if (best_count < MAX_K) best_count++;
    end
    arrival_index++;
    if (last_word) begin
      // zero reads as one, anything above MAX_K saturates
      k = int'(sel_top_k);
      if (k == 0) k = 1;
      if (k > MAX_K) k = MAX_K;
      n = (k < best_count) ? k : best_count;
      for (int i = 0; i < n; i++) begin
        r.rank        = RANK_W'(i + 1);
        r.class_index = best_indices[i];
        r.best_score  = best_scores[i];
        r.final_res   = (i + 1 == n);
        ranked_due    = {ranked_due, r};
      end
      best_count    = 0;
      arrival_index = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued score words in bursts of random length with random
  // gaps between them. A word stays on the bus until it is taken.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_scores
    score_word_t w;
    logic        holding;
    if (rst) begin
      score_ch.valid <= 1'b0;
    end else begin
      holding = score_ch.valid;
      if (score_ch.valid && score_ch.ready) begin
        rank_score(score_ch.score, score_ch.last);
        words_taken++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          score_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          score_ch.valid <= 1'b1;
          score_ch.score <= w.score;
          score_ch.last  <= w.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          score_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction and drives the
  // receiver's ready. Ready steps through four patterns in turn, and on request
  // drops for one long hold.
  // --------------------------------------------------------------------------
  int rx_cycle  = 0;
  int hold_left = 0;

  always @(posedge clk) begin : check_results
    ranked_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (ranked_due.size() == 0) begin
        $error("unexpected result: rank %0d class_index %0d best_score %0d",
               result_ch.rank, result_ch.class_index, result_ch.best_score);
        failures++;
      end else begin
        want = ranked_due.pop_front();
        if (result_ch.rank !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, result_ch.rank);
          failures++;
        end
        if (result_ch.class_index !== want.class_index) begin
          $error("class_index: expected %0d, got %0d", want.class_index,
                 result_ch.class_index);
          failures++;
        end
        if (result_ch.best_score !== want.best_score) begin
          $error("best_score: expected %0d, got %0d", want.best_score,
                 result_ch.best_score);
          failures++;
        end
        if (result_ch.final_res !== want.final_res) begin
          $error("final_res: expected %0d, got %0d", want.final_res,
                 result_ch.final_res);
          failures++;
        end
      end
    end

    rx_cycle++;
    if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= ($urandom_range(0, 1) == 1);
        2: result_ch.ready <= ($urandom_range(0, 4) != 0);
        default: result_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_word(logic signed [SCORE_W-1:0] s, logic last_word);
    score_word_t w;
    w.score = s;
    w.last  = last_word;
    pending_words = {pending_words, w};
    words_queued++;
  endtask

  // Wait until every queued word is taken and every result is in, then let the
  // clock run on: a trailing non-last word may still be in the block.
  task automatic settle();
    do @(posedge clk);
    while (words_taken != words_queued || ranked_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // Register write, issued while the block is idle or holds an open set.
  task automatic set_top_k(logic [TOPK_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    sel_top_k    = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score(score_style_t style);
    case (style)
      SC_FULL: return SCORE_W'($urandom);
      SC_TIES: return SCORE_W'(int'($urandom_range(0, 15)) - 8);
      SC_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return SCORE_MAX;
          1: return SCORE_MIN;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 1) return SCORE_MAX - SCORE_W'($urandom_range(0, 3));
        return SCORE_MIN + SCORE_W'($urandom_range(0, 3));
      end
    endcase
  endfunction

  // One complete set; mostly short, now and then longer than MAX_K so the
  // list overflows and low scores get dropped.
  task automatic queue_random_set(output int len);
    score_style_t style;
    len   = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
    style = score_style_t'($urandom_range(0, 3));
    for (int i = 0; i < len; i++) begin
      // occasionally mix styles within one set
      if ($urandom_range(0, 5) == 0) queue_word(pick_score(score_style_t'($urandom_range(0, 3))),
                                                i == len - 1);
      else queue_word(pick_score(style), i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    int len;
    int group_words;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    score_ch.valid  = 1'b0;
    score_ch.score  = '0;
    score_ch.last   = 1'b0;
    result_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset top_k of 5: range extremes and a tie at the maximum score.
    queue_word(SCORE_MAX, 1'b0);
    queue_word(SCORE_MIN, 1'b0);
    queue_word('0, 1'b0);
    queue_word(SCORE_MAX, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(1, 1'b1);
    settle();

    // Zero top_k reads as one; the tie goes to the lower index.
    set_top_k('0);
    queue_word(-5, 1'b0);
    queue_word(-5, 1'b1);
    settle();

    // top_k far above MAX_K and above the set size: only two results.
    set_top_k(5'd31);
    queue_word(3, 1'b0);
    queue_word(9, 1'b1);
    settle();

    // top_k changed mid-set: the value at the last word decides the count.
    // 17 descending scores fill the list and the lowest one is dropped.
    set_top_k(5'd3);
    for (int i = 0; i < 10; i++) queue_word(SCORE_W'(1000 - i), 1'b0);
    settle();
    set_top_k(5'd16);
    for (int i = 10; i < 17; i++) queue_word(SCORE_W'(1000 - i), i == 16);
    settle();

    // Random part: groups of sets under different top_k settings.
    for (int g = 0; g < 6; g++) begin
      case (g)
        0: set_top_k(5'd16);
        1: set_top_k(5'd1);
        3: set_top_k(5'd31);
        4: set_top_k(5'($urandom_range(2, 15)));
        default: set_top_k(5'($urandom_range(0, 31)));
      endcase
      // receiver backs off for a long while as the sender keeps going
      if (g == 1 || g == 4) holds_asked++;
      group_words = 0;
      while (group_words < 33) begin
        queue_random_set(len);
        group_words += len;
      end
      // leave a set open across the next register write
      if (g == 2) for (int i = 0; i < 5; i++) queue_word(pick_score(SC_FULL), 1'b0);
      settle();
    end
    // close the open set is not needed: group 3 continued it, and all later
    // groups end on a last word

    if (ranked_due.size() != 0) begin
      $error("%0d predicted results never arrived", ranked_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
src/tks_pkg.sv
src/tks_if.sv
src/tks_cell.sv
src/top_k_score_selector.sv
src/tks_checker.sv
bench/tb.sv
